>>> sv/rvm_pkg.sv
`timescale 1ns / 1ps
// rvm_pkg: widths, rail codes, status codes and the job record shared by
// the rail voltage monitor modules. No dependencies.
package rvm_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int GAIN_BITS   = 15;
  localparam int AVG_SHIFT   = 6;
  localparam int SCALED_W    = SAMPLE_BITS + GAIN_BITS;
  localparam int NUM_W       = SCALED_W + 2;
  localparam int Q_W         = GAIN_BITS + 1;
  localparam int R_W         = SCALED_W;
  localparam int MV_W        = 16;
  localparam longint FULL_SCALE = (longint'(1) << SAMPLE_BITS) - 1;

  typedef logic [1:0] rail_t;
  localparam rail_t RAIL_P5  = 2'd0;
  localparam rail_t RAIL_P12 = 2'd1;
  localparam rail_t RAIL_N12 = 2'd2;

  typedef enum logic [1:0] {
    RS_OK     = 2'd0,
    RS_WARN   = 2'd1,
    RS_FAIL   = 2'd2,
    RS_ABSENT = 2'd3
  } status_t;

  typedef struct packed {
    rail_t                  rail;
    logic [SAMPLE_BITS-1:0] avg;
  } rvm_job_t;

  // Millivolt gain per rail: 3300 mV full scale times 2, 4.3 and 9.2.
  function automatic logic [GAIN_BITS-1:0] rail_gain(input rail_t rail);
    logic [GAIN_BITS-1:0] g;
    case (rail)
      RAIL_P12: g = GAIN_BITS'(14190);
      RAIL_N12: g = GAIN_BITS'(30360);
      default:  g = GAIN_BITS'(6600);
    endcase
    return g;
  endfunction

endpackage

>>> sv/rvm_front.sv
`timescale 1ns / 1ps
// rvm_front: takes samples, tracks the round-robin rail and updates the
// per-rail running average. Depends on rvm_pkg.
module rvm_front import rvm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [SAMPLE_BITS-1:0] sample,
  output rvm_job_t               job
);

  rail_t                  rail;
  logic [SAMPLE_BITS-1:0] avg [3];
  logic [SAMPLE_BITS-1:0] cur;
  logic [SAMPLE_BITS+AVG_SHIFT-1:0] sum;
  logic [SAMPLE_BITS-1:0] avg_next;
  rail_t                  rail_next;

  always_comb begin
    case (rail)
      RAIL_P12: cur = avg[1];
      RAIL_N12: cur = avg[2];
      default:  cur = avg[0];
    endcase
    // avg*63 + sample, then floor divide by 64
    sum = {cur, AVG_SHIFT'(0)} - (SAMPLE_BITS+AVG_SHIFT)'(cur)
          + (SAMPLE_BITS+AVG_SHIFT)'(sample);
    avg_next = sum[SAMPLE_BITS+AVG_SHIFT-1:AVG_SHIFT];
    case (rail)
      RAIL_P5:  rail_next = RAIL_P12;
      RAIL_P12: rail_next = RAIL_N12;
      default:  rail_next = RAIL_P5;
    endcase
    job.rail = (rail == RAIL_P12 || rail == RAIL_N12) ? rail : RAIL_P5;
    job.avg  = avg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rail   <= RAIL_P5;
      avg[0] <= '0;
      avg[1] <= '0;
      avg[2] <= '0;
    end else if (accept) begin
      rail <= rail_next;
      case (rail)
        RAIL_P12: avg[1] <= avg_next;
        RAIL_N12: avg[2] <= avg_next;
        default:  avg[0] <= avg_next;
      endcase
    end
  end

endmodule

>>> sv/rvm_fifo.sv
`timescale 1ns / 1ps
// rvm_fifo: two-entry queue of jobs between front and back.
// Depends on rvm_pkg.
module rvm_fifo import rvm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_en,
  input  rvm_job_t wr_job,
  output logic     full,
  output logic     rd_valid,
  input  logic     rd_en,
  output rvm_job_t rd_job
);

  rvm_job_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_job   = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_wr && !do_rd) begin
        count <= count + 2'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> sv/rvm_back.sv
`timescale 1ns / 1ps
// rvm_back: scales the average to millivolts (multiply, divide by full
// scale through end-around folds) and classifies the rail. Depends on rvm_pkg.
module rvm_back import rvm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   job_valid,
  input  rvm_job_t               job,
  output logic                   job_pop,
  output logic                   empty,
  input  logic                   pop,
  output logic [1:0]             rail_index,
  output logic [SAMPLE_BITS-1:0] average_code,
  output logic signed [MV_W-1:0] rail_millivolts,
  output logic [1:0]             rail_status
);

  localparam logic signed [NUM_W-1:0] N12_OFFSET = NUM_W'(longint'(27060) * FULL_SCALE);
  localparam logic [R_W-1:0]          FS_R       = R_W'(FULL_SCALE);
  localparam logic signed [MV_W-1:0]  N12_MV     = MV_W'(27060);

  logic                   advance;
  logic                   s1_valid, s2_valid, s3_valid;
  rvm_job_t               s1_job, s2_job;
  logic [SCALED_W-1:0]    s1_scaled;
  logic [Q_W-1:0]         s2_q;
  logic [R_W-1:0]         s2_r;
  logic signed [NUM_W-1:0] s2_num;

  logic [Q_W-1:0]         q0, qa, qb, qc;
  logic [R_W-1:0]         r0, r1, r2;
  logic signed [NUM_W-1:0] num1;
  logic signed [MV_W-1:0] mv;
  status_t                status;

  function automatic logic signed [NUM_W-1:0] th(input longint mv_val);
    return NUM_W'(mv_val * FULL_SCALE);
  endfunction

  assign advance = !s3_valid || pop;
  assign job_pop = advance && job_valid;
  assign empty   = !s3_valid;

  // first fold: x = q0*(2^B) + low, and 2^B = FS + 1
  always_comb begin
    q0   = Q_W'(s1_scaled >> SAMPLE_BITS);
    r0   = R_W'(s1_scaled[SAMPLE_BITS-1:0]) + R_W'(q0);
    num1 = $signed({2'b00, s1_scaled});
    if (s1_job.rail == RAIL_N12) begin
      num1 = num1 - N12_OFFSET;
    end
  end

  always_comb begin
    r1 = R_W'(s2_r[SAMPLE_BITS-1:0]) + (s2_r >> SAMPLE_BITS);
    qa = s2_q + Q_W'(s2_r >> SAMPLE_BITS);
    r2 = R_W'(r1[SAMPLE_BITS-1:0]) + (r1 >> SAMPLE_BITS);
    qb = qa + Q_W'(r1 >> SAMPLE_BITS);
    qc = (r2 >= FS_R) ? qb + Q_W'(1) : qb;
    mv = $signed(MV_W'(qc));
    if (s2_job.rail == RAIL_N12) begin
      mv = mv - N12_MV;
    end
  end

  always_comb begin
    case (s2_job.rail)
      RAIL_P12: begin
        if (s2_num < th(1000)) begin
          status = RS_ABSENT;
        end else if (s2_num > th(13200) || s2_num < th(10800)) begin
          status = RS_FAIL;
        end else if (s2_num > th(12600) || s2_num < th(11400)) begin
          status = RS_WARN;
        end else begin
          status = RS_OK;
        end
      end
      RAIL_N12: begin
        if (s2_num >= th(-2000)) begin
          status = RS_ABSENT;
        end else if (s2_num > th(-10800) || s2_num < th(-13200)) begin
          status = RS_FAIL;
        end else if (s2_num > th(-11400) || s2_num < th(-12600)) begin
          status = RS_WARN;
        end else begin
          status = RS_OK;
        end
      end
      default: begin
        if (s2_num < th(1000)) begin
          status = RS_ABSENT;
        end else if (s2_num > th(5500) || s2_num < th(4500)) begin
          status = RS_FAIL;
        end else if (s2_num > th(5250) || s2_num < th(4750)) begin
          status = RS_WARN;
        end else begin
          status = RS_OK;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= job_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_job          <= job;
      s1_scaled       <= SCALED_W'(job.avg) * SCALED_W'(rail_gain(job.rail));
      s2_job          <= s1_job;
      s2_q            <= q0;
      s2_r            <= r0;
      s2_num          <= num1;
      rail_index      <= s2_job.rail;
      average_code    <= s2_job.avg;
      rail_millivolts <= mv;
      rail_status     <= status;
    end
  end

endmodule

>>> sv/rail_voltage_monitor.sv
`timescale 1ns / 1ps
// rail_voltage_monitor: an accepted sample is written to the queue at the accepting
// edge, then registered through multiply, first fold, and final fold with classify.
// Throughput is one sample per cycle while results are popped: the back pipeline
// advances when its result register is free or popped; the two-entry queue sets full.
// Synchronous reset clears rail order, all three averages, the queue and pipeline.
// Depends on rvm_pkg, rvm_front, rvm_fifo, rvm_back.
module rail_voltage_monitor import rvm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   empty,
  input  logic                   pop,
  output logic [1:0]             rail_index,
  output logic [SAMPLE_BITS-1:0] average_code,
  output logic signed [MV_W-1:0] rail_millivolts,
  output logic [1:0]             rail_status
);

  logic     accept;
  rvm_job_t front_job;
  logic     q_valid;
  logic     q_pop;
  rvm_job_t q_job;
  rail_t    exp_rail;

  assign accept = push && !full;

  rvm_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .sample (sample),
    .job    (front_job)
  );

  rvm_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept),
    .wr_job   (front_job),
    .full     (full),
    .rd_valid (q_valid),
    .rd_en    (q_pop),
    .rd_job   (q_job)
  );

  rvm_back u_back (
    .clk             (clk),
    .rst             (rst),
    .job_valid       (q_valid),
    .job             (q_job),
    .job_pop         (q_pop),
    .empty           (empty),
    .pop             (pop),
    .rail_index      (rail_index),
    .average_code    (average_code),
    .rail_millivolts (rail_millivolts),
    .rail_status     (rail_status)
  );

  // expected rail of the next result, for checking order only
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_rail <= RAIL_P5;
    end else if (pop && !empty) begin
      exp_rail <= (exp_rail == RAIL_N12) ? RAIL_P5 : exp_rail + 2'd1;
    end
  end

  a_rail_order: assert property (@(posedge clk) disable iff (rst)
    !empty |-> rail_index == exp_rail)
    else $error("result rail out of round-robin order");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result shown right after reset");

  a_low_absent: assert property (@(posedge clk) disable iff (rst)
    (!empty && rail_index != RAIL_N12 && rail_millivolts < 16'sd1000)
      |-> rail_status == RS_ABSENT)
    else $error("positive rail below 1 V not flagged absent");

  a_neg_absent: assert property (@(posedge clk) disable iff (rst)
    (!empty && rail_index == RAIL_N12 && rail_millivolts >= -16'sd2000)
      |-> rail_status == RS_ABSENT)
    else $error("negative rail above -2 V not flagged absent");

endmodule

>>> tb/sv/rail_voltage_monitor_test.sv
`timescale 1ns / 1ps
// rail_voltage_monitor_test: random and directed samples with an in-order
// prediction of averages, millivolts and status for each rail.
// Depends on rvm_pkg and rail_voltage_monitor.
module rail_voltage_monitor_test;
  import rvm_pkg::*;

  localparam int TARGET_ITEMS = 1600;
  localparam int QUIET_TAIL   = 200;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int CODE_MAX     = (1 << SAMPLE_BITS) - 1;

  typedef struct {
    rail_t                   rail;
    logic [SAMPLE_BITS-1:0]  avg;
    logic signed [MV_W-1:0]  mv;
    status_t                 status;
  } reading_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   pop = 1'b0;
  logic [SAMPLE_BITS-1:0] sample = '0;
  logic                   full;
  logic                   empty;
  logic [1:0]             rail_index;
  logic [SAMPLE_BITS-1:0] average_code;
  logic signed [MV_W-1:0] rail_millivolts;
  logic [1:0]             rail_status;

  logic [SAMPLE_BITS-1:0] pending_samples[$];
  reading_t               expected_readings[$];

  logic [SAMPLE_BITS-1:0] avg_state[3];
  rail_t                  rail_turn;
  bit                     item_taken;
  int                     push_gap;
  int                     pop_stall;
  int                     cycle_count;
  int                     samples_taken;
  int                     readings_checked;
  int                     mismatches;
  int                     status_seen[4];

  rail_voltage_monitor u_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .sample(sample),
    .empty(empty),
    .pop(pop),
    .rail_index(rail_index),
    .average_code(average_code),
    .rail_millivolts(rail_millivolts),
    .rail_status(rail_status)
  );

  always #5 clk = ~clk;

  function automatic logic [SAMPLE_BITS-1:0] next_average(
      input logic [SAMPLE_BITS-1:0] old_avg, input logic [SAMPLE_BITS-1:0] s);
    longint acc;
    acc = (longint'(old_avg) * 63 + longint'(s)) / 64;
    return acc[SAMPLE_BITS-1:0];
  endfunction

  function automatic reading_t compute_reading(input rail_t rail,
                                               input logic [SAMPLE_BITS-1:0] avg);
    reading_t r;
    longint gain, nom, anom, scaled, num, mv, dev;
    case (rail)
      RAIL_P12: begin
        gain = 14190;
        nom = 12000;
      end
      RAIL_N12: begin
        gain = 30360;
        nom = -12000;
      end
      default: begin
        gain = 6600;
        nom = 5000;
      end
    endcase
    scaled = longint'(avg) * gain;
    mv = scaled / FULL_SCALE;
    num = scaled;
    if (rail == RAIL_N12) begin
      mv -= 27060;
      num -= 27060 * FULL_SCALE;
    end
    anom = (nom < 0) ? -nom : nom;
    dev = num - nom * FULL_SCALE;
    if (dev < 0) dev = -dev;
    r.rail = rail;
    r.avg = avg;
    r.mv = mv[MV_W-1:0];
    if ((rail != RAIL_N12 && num < 1000 * FULL_SCALE) ||
        (rail == RAIL_N12 && num >= -2000 * FULL_SCALE))
      r.status = RS_ABSENT;
    else if (dev > (anom / 10) * FULL_SCALE)
      r.status = RS_FAIL;
    else if (dev > (anom / 20) * FULL_SCALE)
      r.status = RS_WARN;
    else
      r.status = RS_OK;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint want_v,
                                 input longint got_v);
    mismatches++;
    $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
  endtask

  // Sender: an offered item is held until taken.
  always @(negedge clk) begin
    if (!rst) begin
      if (push && !item_taken) begin
      end else if (push_gap > 0) begin
        push <= 1'b0;
        push_gap--;
      end else if (pending_samples.size() > QUIET_TAIL && $urandom_range(0, 11) == 0) begin
        push <= 1'b0;
        push_gap = $urandom_range(0, 15);
      end else if (pending_samples.size() > 0) begin
        push <= 1'b1;
        sample <= pending_samples[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver stalls.
  always @(negedge clk) begin
    if (!rst) begin
      if (pop_stall > 0) begin
        pop <= 1'b0;
        pop_stall--;
      end else if (pending_samples.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        pop_stall = $urandom_range(0, 15);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    reading_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d items pending, %0d readings outstanding",
               $time, pending_samples.size(), expected_readings.size());
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst) begin
      avg_state = '{default: '0};
      rail_turn = RAIL_P5;
      item_taken = 1'b0;
    end else begin
      item_taken = push && !full;
      if (item_taken) begin
        void'(pending_samples.pop_front());
        avg_state[rail_turn] = next_average(avg_state[rail_turn], sample);
        expected_readings.push_back(compute_reading(rail_turn, avg_state[rail_turn]));
        rail_turn = (rail_turn == RAIL_N12) ? RAIL_P5 : rail_t'(rail_turn + 1);
        samples_taken++;
      end
      if (pop && !empty) begin
        if (expected_readings.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected reading rail %0d avg %0d mv %0d status %0d",
                   $time, rail_index, average_code, rail_millivolts, rail_status);
        end else begin
          want = expected_readings.pop_front();
          readings_checked++;
          status_seen[rail_status]++;
          if (rail_index !== want.rail)
            report_mismatch("rail_index", want.rail, rail_index);
          if (average_code !== want.avg)
            report_mismatch("average_code", want.avg, average_code);
          if (rail_millivolts !== want.mv)
            report_mismatch("rail_millivolts", want.mv, rail_millivolts);
          if (rail_status !== want.status)
            report_mismatch("rail_status", want.status, rail_status);
        end
      end
    end
  end

  // Stimulus: a shadow of the averages steers each rail toward a target so
  // that all status bands are visited, with some raw noise mixed in.
  initial begin
    logic [SAMPLE_BITS-1:0] gen_avg[3];
    int                     gen_rail;
    int                     target[3];
    int                     nominal_code[3];
    int                     directed[$];
    int                     random_count;
    int                     rounds;
    int                     s;
    int                     spread;

    gen_avg = '{default: '0};
    gen_rail = 0;
    nominal_code[0] = 5000 * CODE_MAX / 6600;
    nominal_code[1] = 12000 * CODE_MAX / 14190;
    nominal_code[2] = 15060 * CODE_MAX / 30360;

    directed = '{0, 0, 0, CODE_MAX, CODE_MAX, CODE_MAX, 'hAAA, 'h555, 'hAAA, 'h555,
                 'hAAA, 'h555, 'h800, 'h7FF, 1, CODE_MAX, 0, CODE_MAX, 0, CODE_MAX,
                 0, 'hFFE, 'h001, 'h0F0};
    foreach (directed[i]) begin
      pending_samples.push_back(directed[i][SAMPLE_BITS-1:0]);
      gen_avg[gen_rail] = next_average(gen_avg[gen_rail], directed[i][SAMPLE_BITS-1:0]);
      gen_rail = (gen_rail + 1) % 3;
    end

    random_count = 0;
    while (random_count < TARGET_ITEMS) begin
      for (int r = 0; r < 3; r++) begin
        if ($urandom_range(0, 3) == 0) begin
          target[r] = $urandom_range(0, CODE_MAX);
        end else begin
          spread = nominal_code[r] * 13 / 100;
          target[r] = nominal_code[r] + $urandom_range(0, 2 * spread) - spread;
        end
      end
      rounds = $urandom_range(20, 80);
      for (int k = 0; k < 3 * rounds && random_count < TARGET_ITEMS; k++) begin
        if ($urandom_range(0, 9) == 0)
          s = $urandom_range(0, CODE_MAX);
        else if (gen_avg[gen_rail] + 64 < target[gen_rail])
          s = CODE_MAX;
        else if (gen_avg[gen_rail] > target[gen_rail] + 64)
          s = 0;
        else
          s = target[gen_rail] + $urandom_range(0, 60) - 30;
        s = (s < 0) ? 0 : (s > CODE_MAX) ? CODE_MAX : s;
        pending_samples.push_back(s[SAMPLE_BITS-1:0]);
        gen_avg[gen_rail] = next_average(gen_avg[gen_rail], s[SAMPLE_BITS-1:0]);
        gen_rail = (gen_rail + 1) % 3;
        random_count++;
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0 || expected_readings.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d samples in, %0d readings checked, %0d mismatches", samples_taken,
             readings_checked, mismatches);
    $display("status seen: ok %0d, warn %0d, fail %0d, absent %0d", status_seen[RS_OK],
             status_seen[RS_WARN], status_seen[RS_FAIL], status_seen[RS_ABSENT]);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
